// ===== sv/rpe_pkg.sv =====
// Shared types, constants and lookup functions for the pose error block.
`timescale 1ns / 1ps
package rpe_pkg;

   localparam int unsigned SQRT_STEPS   = 35;
   localparam int unsigned CORDIC_STEPS = 31;
   localparam int unsigned POS_SQ_TERMS = 3;
   localparam int unsigned QMUL_TERMS   = 16;
   localparam logic [33:0] HALF_PI_Q30  = 34'd1686629713;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] quat_x;
      logic [31:0] quat_y;
      logic [31:0] quat_z;
      logic [31:0] quat_w;
   } req_type;

   typedef struct packed {
      logic [33:0] position_error;
      logic [31:0] rotation_error;
      logic        status;
      logic        within_tolerance;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_PSQ, S_PRLD, S_PROOT, S_PSAVE, S_QMUL, S_QABS, S_NORM,
      S_VSQ, S_VRLD, S_VROOT, S_CINIT, S_CORDIC, S_FIN
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_STORE, DP_CAPTURE, DP_PSQ, DP_ROOT_LOAD, DP_ROOT_STEP, DP_PSAVE,
      DP_QMUL, DP_QABS, DP_NORM, DP_VSQ, DP_CINIT, DP_CORDIC, DP_RESULT, DP_DEGEN
   } dp_op_type;

   typedef struct packed {
      dp_op_type   op;
      logic [5:0]  step;
   } dp_cmd_type;

   typedef struct packed {
      logic degen;
      logic norm_ok;
   } dp_status_type;

   // atan(2^-i) in units of 2^-30 rad
   function automatic logic [29:0] atan_lut(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         default: v = (i <= 5'd30) ? (30'd1 << (5'd30 - i)) : 30'd0;
      endcase
      return v;
   endfunction

   // relative quaternion conj(E)*A: term j of component k uses e[e_idx], a[a_idx]
   function automatic logic [1:0] qmul_e_idx(input logic [1:0] j);
      logic [1:0] v;
      case (j)
         2'd0:    v = 2'd3;
         2'd1:    v = 2'd0;
         2'd2:    v = 2'd1;
         default: v = 2'd2;
      endcase
      return v;
   endfunction

   function automatic logic [1:0] qmul_a_idx(input logic [3:0] kj);
      logic [1:0] v;
      case (kj)
         4'd0:  v = 2'd0;  4'd1:  v = 2'd3;  4'd2:  v = 2'd2;  4'd3:  v = 2'd1;
         4'd4:  v = 2'd1;  4'd5:  v = 2'd2;  4'd6:  v = 2'd3;  4'd7:  v = 2'd0;
         4'd8:  v = 2'd2;  4'd9:  v = 2'd1;  4'd10: v = 2'd0;  4'd11: v = 2'd3;
         4'd12: v = 2'd3;  4'd13: v = 2'd0;  4'd14: v = 2'd1;  4'd15: v = 2'd2;
         default: v = 2'd0;
      endcase
      return v;
   endfunction

   function automatic logic qmul_neg(input logic [3:0] kj);
      logic v;
      case (kj)
         4'd1, 4'd2, 4'd6, 4'd7, 4'd9, 4'd11: v = 1'b1;
         default: v = 1'b0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/rpe_ctrl.sv =====
// Sequencer that stores load items and steps the pose error datapath through one compare item.
`timescale 1ns / 1ps
module rpe_ctrl
   import rpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_operation,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           deg_ff, deg_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         deg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         deg_ff       <= deg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff + 6'd1;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.op       = DP_NOP;
      cmd.step     = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               if (req_operation == OP_LOAD) begin
                  cmd.op = DP_STORE;
               end else begin
                  cmd.op   = DP_CAPTURE;
                  deg_in   = status.degen;
                  state_in = status.degen ? S_FIN : S_PSQ;
               end
            end
         end
         S_PSQ: begin
            cmd.op = DP_PSQ;
            if (cnt_ff == 6'(POS_SQ_TERMS - 1)) state_in = S_PRLD;
         end
         S_PRLD: begin
            cmd.op   = DP_ROOT_LOAD;
            cnt_in   = '0;
            state_in = S_PROOT;
         end
         S_PROOT: begin
            cmd.op = DP_ROOT_STEP;
            if (cnt_ff == 6'(SQRT_STEPS - 1)) state_in = S_PSAVE;
         end
         S_PSAVE: begin
            cmd.op   = DP_PSAVE;
            cnt_in   = '0;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            cmd.op = DP_QMUL;
            if (cnt_ff == 6'(QMUL_TERMS - 1)) state_in = S_QABS;
         end
         S_QABS: begin
            cmd.op   = DP_QABS;
            state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = DP_NORM;
            cnt_in = '0;
            if (status.norm_ok) state_in = S_VSQ;
         end
         S_VSQ: begin
            cmd.op = DP_VSQ;
            if (cnt_ff == 6'(POS_SQ_TERMS - 1)) state_in = S_VRLD;
         end
         S_VRLD: begin
            cmd.op   = DP_ROOT_LOAD;
            cnt_in   = '0;
            state_in = S_VROOT;
         end
         S_VROOT: begin
            cmd.op = DP_ROOT_STEP;
            if (cnt_ff == 6'(SQRT_STEPS - 1)) state_in = S_CINIT;
         end
         S_CINIT: begin
            cmd.op   = DP_CINIT;
            cnt_in   = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.op = DP_CORDIC;
            if (cnt_ff == 6'(CORDIC_STEPS - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = deg_ff ? DP_DEGEN : DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/rpe_datapath.sv =====
// Pose store, shared multipliers, digit-by-digit square root and CORDIC unit.
`timescale 1ns / 1ps
module rpe_datapath
   import rpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_type       req_data,
   input  logic [33:0]   pos_tol,
   input  logic [31:0]   rot_tol,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   logic [31:0]        exp_pos_ff [3];
   logic [31:0]        exp_quat_ff [4];
   logic [31:0]        act_pos_ff [3];
   logic [31:0]        act_quat_ff [4];
   logic signed [65:0] r_ff [4];
   logic [64:0]        m_ff [4];
   logic [65:0]        acc_ff;
   logic [69:0]        rad_ff;
   logic [36:0]        rem_ff;
   logic [34:0]        root_ff;
   logic [33:0]        pos_err_ff;
   logic signed [59:0] x_ff, y_ff;
   logic signed [33:0] z_ff;
   rsp_type            rsp_ff;

   logic [31:0]        req_pos [3];
   logic [31:0]        req_quat [4];
   logic signed [32:0] pdiff;
   logic [31:0]        pabs;
   logic [63:0]        psq;
   logic [1:0]         k_idx;
   logic signed [63:0] qprod;
   logic signed [65:0] qterm;
   logic [61:0]        vsq;
   logic [38:0]        rem_t, trial;
   logic               big;
   logic signed [59:0] dx, dy;
   logic signed [33:0] atan_s, z_clamp;
   logic [31:0]        rot_err;
   logic [1:0]         sel;

   assign req_pos  = '{req_data.pos_x, req_data.pos_y, req_data.pos_z};
   assign req_quat = '{req_data.quat_x, req_data.quat_y, req_data.quat_z, req_data.quat_w};
   assign sel      = cmd.step[1:0];

   always_comb begin
      pdiff  = $signed({exp_pos_ff[sel][31], exp_pos_ff[sel]})
             - $signed({act_pos_ff[sel][31], act_pos_ff[sel]});
      pabs   = pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
      psq    = pabs * pabs;
      k_idx  = cmd.step[3:2];
      qprod  = $signed(exp_quat_ff[qmul_e_idx(sel)]) *
               $signed(act_quat_ff[qmul_a_idx(cmd.step[3:0])]);
      qterm  = qmul_neg(cmd.step[3:0]) ? -66'(qprod) : 66'(qprod);
      vsq    = m_ff[sel][30:0] * m_ff[sel][30:0];
      rem_t  = {rem_ff, rad_ff[69:68]};
      trial  = {2'b00, root_ff, 2'b01};
      big    = 1'b0;
      for (int i = 0; i < 4; i++) big = big | (|m_ff[i][64:31]);
      dx     = y_ff >>> cmd.step[4:0];
      dy     = x_ff >>> cmd.step[4:0];
      atan_s = $signed({4'b0000, atan_lut(cmd.step[4:0])});
      if (z_ff[33])               z_clamp = '0;
      else if (z_ff > $signed(HALF_PI_Q30)) z_clamp = $signed(HALF_PI_Q30);
      else                        z_clamp = z_ff;
      rot_err = {z_clamp[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) exp_pos_ff[i] <= '0;
         for (int i = 0; i < 4; i++) exp_quat_ff[i] <= '0;
      end else if (cmd.op == DP_STORE) begin
         exp_pos_ff  <= req_pos;
         exp_quat_ff <= req_quat;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CAPTURE: begin
            act_pos_ff  <= req_pos;
            act_quat_ff <= req_quat;
         end
         DP_PSQ:       acc_ff <= (sel == 2'd0) ? {2'b00, psq} : acc_ff + {2'b00, psq};
         DP_VSQ:       acc_ff <= (sel == 2'd0) ? {4'b0, vsq} : acc_ff + {4'b0, vsq};
         DP_ROOT_LOAD: begin
            rad_ff  <= {4'b0, acc_ff};
            rem_ff  <= '0;
            root_ff <= '0;
         end
         DP_ROOT_STEP: begin
            rad_ff <= {rad_ff[67:0], 2'b00};
            if (rem_t >= trial) begin
               rem_ff  <= 37'(rem_t - trial);
               root_ff <= {root_ff[33:0], 1'b1};
            end else begin
               rem_ff  <= rem_t[36:0];
               root_ff <= {root_ff[33:0], 1'b0};
            end
         end
         DP_PSAVE:     pos_err_ff <= root_ff[33:0];
         DP_QMUL:      r_ff[k_idx] <= (sel == 2'd0) ? qterm : r_ff[k_idx] + qterm;
         DP_QABS: begin
            for (int i = 0; i < 4; i++)
               m_ff[i] <= r_ff[i][65] ? 65'(-r_ff[i]) : r_ff[i][64:0];
         end
         DP_NORM: begin
            if (big) for (int i = 0; i < 4; i++) m_ff[i] <= m_ff[i] >> 1;
         end
         DP_CINIT: begin
            x_ff <= $signed({5'b0, m_ff[3][30:0], 24'b0});
            y_ff <= $signed({4'b0, root_ff[31:0], 24'b0});
            z_ff <= '0;
         end
         DP_CORDIC: begin
            // skip once y has reached zero
            if (y_ff != 0) begin
               if (!y_ff[59]) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_s;
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_s;
               end
            end
         end
         DP_RESULT: begin
            rsp_ff.position_error   <= pos_err_ff;
            rsp_ff.rotation_error   <= rot_err;
            rsp_ff.status           <= 1'b0;
            rsp_ff.within_tolerance <= (pos_err_ff <= pos_tol) && (rot_err <= rot_tol);
         end
         DP_DEGEN: begin
            rsp_ff.position_error   <= '0;
            rsp_ff.rotation_error   <= '0;
            rsp_ff.status           <= 1'b1;
            rsp_ff.within_tolerance <= 1'b0;
         end
         default: ;
      endcase
   end

   assign status.degen   = ((exp_quat_ff[0] | exp_quat_ff[1] | exp_quat_ff[2] | exp_quat_ff[3])
                            == 32'd0) ||
                           ((req_data.quat_x | req_data.quat_y | req_data.quat_z | req_data.quat_w)
                            == 32'd0);
   assign status.norm_ok = !big;
   assign rsp_data       = rsp_ff;

endmodule

// ===== sv/rigid_pose_error.sv =====
// Top level of the pose error block: register port, sequencer and datapath.
`timescale 1ns / 1ps
// Compares a pose against a stored expected pose. A load item (operation 0)
// stores the pose and gives no result. A compare item gives the translation
// distance (Q18.16), the relative rotation angle (Q2.30 rad, 0 to pi),
// a degenerate status when either quaternion is all zeros, and a
// within-tolerance bit from the two registers (position at 0x0, rotation
// at 0x8, 64-bit data). A compare runs two 35-step digit-by-digit square
// roots, 16 passes through one 32x32 multiplier, a normalizing shift of
// one bit per cycle and 31 CORDIC vectoring steps; a degenerate compare
// goes straight to its result. One item is worked on at a time; a finished
// result waits in its output register while the next item is accepted.
module rigid_pose_error
   import rpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   logic [33:0]   pos_tol_ff;
   logic [31:0]   rot_tol_ff;
   logic          wr_en;
   dp_cmd_type    cmd;
   dp_status_type status;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_tol_ff <= '0;
         rot_tol_ff <= '0;
      end else if (wr_en) begin
         if (paddr[3]) rot_tol_ff <= pwdata[31:0];
         else          pos_tol_ff <= pwdata[33:0];
      end
   end

   assign prdata = paddr[3] ? {32'b0, rot_tol_ff} : {30'b0, pos_tol_ff};

   rpe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   rpe_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .pos_tol  (pos_tol_ff),
      .rot_tol  (rot_tol_ff),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the rigid pose error block.
`timescale 1ns / 1ps
module testbench
   import rpe_pkg::*;
();

   localparam longint unsigned POS_TOL_MAX = 64'h3_FFFF_FFFF;
   localparam longint unsigned ROT_TOL_MAX = 64'd3373259426;
   localparam longint HALF_PI = 64'd1686629713;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [3:0] ADDR_POS_TOL = 4'h0;
   localparam logic [3:0] ADDR_ROT_TOL = 4'h8;

   class pose_error_board;
      logic [31:0]  stored_pose[7];
      logic [33:0]  pos_tol;
      logic [31:0]  rot_tol;
      rsp_type      pending_q[$];
      int           mismatches;
      int           loads, compares, degenerate_seen, in_tol_seen;
      longint       arctan[31];

      function new();
         arctan = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                    128, 64, 32, 16, 8, 4, 2, 1};
         foreach (stored_pose[i]) stored_pose[i] = '0;
         pos_tol = '0;
         rot_tol = '0;
      endfunction

      function automatic longint unsigned distance(logic [31:0] a[3], logic [31:0] b[3]);
         logic [127:0] sq, cc;
         longint d;
         longint unsigned ad, sqr, c;
         sq = '0;
         for (int i = 0; i < 3; i++) begin
            d = longint'($signed(a[i])) - longint'($signed(b[i]));
            ad = d < 0 ? -d : d;
            sq = sq + {64'b0, ad * ad};
         end
         sqr = 0;
         for (int k = 34; k >= 0; k--) begin
            c = sqr | (64'd1 << k);
            cc = {64'b0, c} * {64'b0, c};
            if (cc <= sq) sqr = c;
         end
         return sqr & POS_TOL_MAX;
      endfunction

      function automatic longint unsigned angle(longint e[4], longint a[4]);
         logic signed [127:0] r[4];
         logic [127:0] mag[4], mx;
         longint unsigned m[4], v2, vn, c;
         longint x, y, z, dx, dy;
         int s;
         r[0] = 128'(e[3]*a[0]) - 128'(e[0]*a[3]) - 128'(e[1]*a[2]) + 128'(e[2]*a[1]);
         r[1] = 128'(e[3]*a[1]) + 128'(e[0]*a[2]) - 128'(e[1]*a[3]) - 128'(e[2]*a[0]);
         r[2] = 128'(e[3]*a[2]) - 128'(e[0]*a[1]) + 128'(e[1]*a[0]) - 128'(e[2]*a[3]);
         r[3] = 128'(e[3]*a[3]) + 128'(e[0]*a[0]) + 128'(e[1]*a[1]) + 128'(e[2]*a[2]);
         mx = '0;
         for (int i = 0; i < 4; i++) begin
            mag[i] = r[i] < 0 ? -r[i] : r[i];
            if (mag[i] > mx) mx = mag[i];
         end
         s = 0;
         while ((mx >> s) >= 128'h8000_0000) s++;
         for (int i = 0; i < 4; i++) m[i] = 64'(mag[i] >> s);
         v2 = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
         vn = 0;
         for (int b = 31; b >= 0; b--) begin
            c = vn | (64'd1 << b);
            if (c * c <= v2) vn = c;
         end
         x = m[3] << 24;
         y = vn << 24;
         z = 0;
         for (int i = 0; i < 31; i++) begin
            if (y == 0) break;
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += arctan[i];
            end else begin
               x -= dx; y += dy; z -= arctan[i];
            end
         end
         if (z < 0) z = 0;
         if (z > HALF_PI) z = HALF_PI;
         z = z * 2;
         if (z > longint'(ROT_TOL_MAX)) z = ROT_TOL_MAX;
         return z;
      endfunction

      function void note_request(req_type r);
         logic [31:0] act_pos[3], exp_pos[3];
         longint e[4], a[4];
         bit e_zero, a_zero;
         rsp_type res;
         if (r.operation == OP_LOAD) begin
            stored_pose = '{r.pos_x, r.pos_y, r.pos_z, r.quat_x, r.quat_y, r.quat_z,
                            r.quat_w};
            loads++;
            return;
         end
         compares++;
         act_pos = '{r.pos_x, r.pos_y, r.pos_z};
         exp_pos = '{stored_pose[0], stored_pose[1], stored_pose[2]};
         a = '{$signed(r.quat_x), $signed(r.quat_y), $signed(r.quat_z), $signed(r.quat_w)};
         for (int i = 0; i < 4; i++) e[i] = $signed(stored_pose[3+i]);
         e_zero = (e[0] == 0 && e[1] == 0 && e[2] == 0 && e[3] == 0);
         a_zero = (a[0] == 0 && a[1] == 0 && a[2] == 0 && a[3] == 0);
         if (e_zero || a_zero) begin
            res = '{position_error: '0, rotation_error: '0, status: 1'b1,
                    within_tolerance: 1'b0};
         end else begin
            res.position_error = distance(exp_pos, act_pos);
            res.rotation_error = angle(e, a);
            res.status = 1'b0;
            res.within_tolerance = res.position_error <= pos_tol &&
                                   res.rotation_error <= rot_tol;
         end
         pending_q.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            $error("result with nothing pending: %p", got);
            mismatches++;
            return;
         end
         want = pending_q.pop_front();
         if (got.status) degenerate_seen++;
         if (got.within_tolerance) in_tol_seen++;
         if (got.position_error !== want.position_error) begin
            $error("position_error: expected %0d, got %0d", want.position_error,
                   got.position_error);
            mismatches++;
         end
         if (got.rotation_error !== want.rotation_error) begin
            $error("rotation_error: expected %0d, got %0d", want.rotation_error,
                   got.rotation_error);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.within_tolerance !== want.within_tolerance) begin
            $error("within_tolerance: expected %0d, got %0d", want.within_tolerance,
                   got.within_tolerance);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;

   pose_error_board board = new();
   int  cycles = 0;
   bit  no_gaps = 0;
   bit  long_hold = 0;

   rigid_pose_error dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 7);
         if (long_hold) begin
            n = 800;
            long_hold = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         board.check_result(rsp_data);
      end
   end

   task automatic send_item(req_type r);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_request(r);
   endtask

   // drop valid, drain all results, then let trailing loads settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [3:0] addr, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_POS_TOL) board.pos_tol = value[33:0];
      else board.rot_tol = value[31:0];
   endtask

   task automatic set_tolerances(logic [63:0] pos, logic [63:0] rot);
      wait_idle();
      write_reg(ADDR_POS_TOL, pos);
      write_reg(ADDR_ROT_TOL, rot);
   endtask

   function automatic req_type make_item(logic op, logic [31:0] px, logic [31:0] py,
         logic [31:0] pz, logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
         logic [31:0] qw);
      return '{operation: op, pos_x: px, pos_y: py, pos_z: pz, quat_x: qx, quat_y: qy,
               quat_z: qz, quat_w: qw};
   endfunction

   function automatic logic [31:0] near(logic [31:0] v, int spread);
      return v + $urandom_range(0, 2*spread) - spread;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int kind;
      kind = $urandom_range(0, 19);
      r.operation = $urandom_range(0, 2) != 0 ? OP_COMPARE : OP_LOAD;
      if (kind < 12) begin
         // close to the stored pose so the tolerance bit is exercised
         r.pos_x = near(board.stored_pose[0], 1 << $urandom_range(0, 20));
         r.pos_y = near(board.stored_pose[1], 1 << $urandom_range(0, 20));
         r.pos_z = near(board.stored_pose[2], 1 << $urandom_range(0, 20));
         r.quat_x = near(board.stored_pose[3], 1 << $urandom_range(0, 28));
         r.quat_y = near(board.stored_pose[4], 1 << $urandom_range(0, 28));
         r.quat_z = near(board.stored_pose[5], 1 << $urandom_range(0, 28));
         r.quat_w = near(board.stored_pose[6], 1 << $urandom_range(0, 28));
      end else begin
         r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
         r.quat_x = $urandom; r.quat_y = $urandom; r.quat_z = $urandom;
         r.quat_w = $urandom;
      end
      if (kind == 19) {r.quat_x, r.quat_y, r.quat_z, r.quat_w} = '0;
      return r;
   endfunction

   initial begin
      localparam logic [31:0] ONE = 32'h4000_0000;
      localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
      localparam logic [31:0] MINV = 32'h8000_0000;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero tolerances from reset; compare before any load is degenerate
      send_item(make_item(OP_COMPARE, 1, 2, 3, 0, 0, 0, ONE));
      send_item(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, ONE));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 0, 0, 0, ONE));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_COMPARE, 5, 0, 0, ONE, 0, 0, 0));

      set_tolerances(POS_TOL_MAX, ROT_TOL_MAX);
      send_item(make_item(OP_LOAD, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV));
      send_item(make_item(OP_COMPARE, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV));
      send_item(make_item(OP_COMPARE, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV));
      send_item(make_item(OP_COMPARE, MINV, MAXV, 0, MINV, MAXV, MINV, MAXV));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      send_item(make_item(OP_LOAD, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 0, 0, 0, ONE));
      send_item(make_item(OP_LOAD, 0, 32'hFFFF_0000, 0, 0, 0, 0, ONE));
      send_item(make_item(OP_COMPARE, 32'h0003_0000, 32'h0004_0000, 0, 0, ONE, 0, 0));
      send_item(make_item(OP_COMPARE, 0, 0, 32'h0000_0001, 0, 0, 0, 32'hC000_0000));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 32'h2D41_3CCD, 0, 0, 32'h2D41_3CCD));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 1, 0, 0, ONE));

      set_tolerances(64'd65536, 64'd1 << 28);
      send_item(make_item(OP_COMPARE, 0, 32'hFFFF_0000, 32'h0001_0000, 0, 0, 0, ONE));
      send_item(make_item(OP_COMPARE, 0, 32'hFFFF_0000, 32'h0001_0001, 1, 0, 0, ONE));
      send_item(make_item(OP_COMPARE, 0, 0, 0, 32'h1000_0000, 0, 0, ONE));

      // random phases: each with its own tolerances; one runs without gaps, one has a long receiver hold-off
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_tolerances(64'(POS_TOL_MAX), 64'd0);
            1: set_tolerances(64'd0, ROT_TOL_MAX);
            default: set_tolerances(64'({$urandom}) & (POS_TOL_MAX >> $urandom_range(0, 16)),
                                    64'($urandom_range(0, 32'd3373259426))
                                    >> $urandom_range(0, 8));
         endcase
         no_gaps = (phase == 2);
         if (phase == 1) long_hold = 1;
         repeat (100) send_item(random_item());
      end
      no_gaps = 0;

      wait_idle();
      $display("covered %0d loads and %0d compares", board.loads, board.compares);
      $display("results: %0d degenerate, %0d within tolerance",
               board.degenerate_seen, board.in_tol_seen);
      if (board.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
